// ----- sv/pft_pkg.sv -----
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants for the pose frame transform
// Widths, command and register codes, the arctangent table of the rotation
// cells and the transaction tag that travels down the pipeline.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int GUARD_BITS = 16;
    localparam int GAIN_W     = 30;
    localparam int GAIN_SHIFT = GAIN_W - GUARD_BITS;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    localparam int ZW         = 32;
    localparam int ATAN_IDX_W = 5;

    // operand after position subtract and negate
    localparam int V_W  = COORD_WIDTH + 2;
    localparam int LO_W = V_W / 2;
    localparam int HI_W = V_W - LO_W;
    localparam int PL_W = LO_W + GAIN_W;
    localparam int PH_W = HI_W + GAIN_W + 1;
    localparam int S_W  = V_W + GAIN_W + 1;

    // rotation datapath and rounded result
    localparam int DP_W = COORD_WIDTH + GUARD_BITS + 4;
    localparam int R_W  = DP_W - GUARD_BITS;

    localparam int PIPE_LATENCY = CORDIC_STAGES + 5;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_PT_TO_GLOBAL  = 2'd0,
        CMD_PT_TO_LOCAL   = 2'd1,
        CMD_ANG_TO_GLOBAL = 2'd2,
        CMD_ANG_TO_LOCAL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_POSE_X       = 2'd0,
        REG_POSE_Y       = 2'd1,
        REG_POSE_HEADING = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                   valid;
        cmd_t                   cmd;
        logic [ANGLE_WIDTH-1:0] ang;
    } tag_t;

    function automatic logic [ZW-1:0] atan_value(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZW-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/pft_prescale.sv -----
// ----------------------------------------------------------------------------
// pft_prescale: operand setup and gain prescale
// Subtracts the position for point to local, folds the angle to the right half
// plane, scales each coordinate by the rotation gain in two partial products.
// ----------------------------------------------------------------------------
module pft_prescale (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic [1:0]                             cmd,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] in_x,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] in_y,
    input  logic [pft_pkg::ANGLE_WIDTH-1:0]        in_angle,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] pose_x,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] pose_y,
    input  logic [pft_pkg::ANGLE_WIDTH-1:0]        pose_heading,
    output pft_pkg::tag_t                          tag_o,
    output logic signed [pft_pkg::DP_W-1:0]        x_o,
    output logic signed [pft_pkg::DP_W-1:0]        y_o,
    output logic [pft_pkg::ZW-1:0]                 z_o
);
    import pft_pkg::*;

    localparam logic signed [GAIN_W:0] GAIN_S = {1'b0, GAIN_Q30};

    tag_t                tag1_reg, tag1_next, tag2_reg, tag3_reg;
    logic signed [V_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [ZW-1:0]       z1_reg, z1_next, z2_reg, z3_reg;
    logic [PL_W-1:0]     plx_reg, plx_next, ply_reg, ply_next;
    logic signed [PH_W-1:0] phx_reg, phx_next, phy_reg, phy_next;
    logic signed [DP_W-1:0] x3_reg, x3_next, y3_reg, y3_next;

    logic signed [V_W-1:0] ixe, iye, pxe, pye;
    logic [ZW-1:0]         h32;
    cmd_t                  cmd_c;
    logic signed [HI_W-1:0] vhx, vhy;
    logic signed [S_W-1:0] sumx, sumy, shx, shy;

    // setup stage
    always_comb
    begin
        cmd_c = cmd_t'(cmd);
        ixe   = {{2{in_x[COORD_WIDTH-1]}}, in_x};
        iye   = {{2{in_y[COORD_WIDTH-1]}}, in_y};
        pxe   = {{2{pose_x[COORD_WIDTH-1]}}, pose_x};
        pye   = {{2{pose_y[COORD_WIDTH-1]}}, pose_y};
        h32   = {pose_heading, {(ZW-ANGLE_WIDTH){1'b0}}};
        if (cmd_c == CMD_PT_TO_LOCAL)
        begin
            vx_next = ixe - pxe;
            vy_next = iye - pye;
            z1_next = ZW'(0) - h32;
        end
        else
        begin
            vx_next = ixe;
            vy_next = iye;
            z1_next = h32;
        end
        if (z1_next[ZW-1] ^ z1_next[ZW-2])
        begin
            vx_next = -vx_next;
            vy_next = -vy_next;
            z1_next = {~z1_next[ZW-1], z1_next[ZW-2:0]};
        end
        tag1_next.valid = accept;
        tag1_next.cmd   = cmd_c;
        case (cmd_c)
            CMD_ANG_TO_GLOBAL: tag1_next.ang = in_angle + pose_heading;
            CMD_ANG_TO_LOCAL:  tag1_next.ang = in_angle - pose_heading;
            default:           tag1_next.ang = '0;
        endcase
    end

    // partial products
    always_comb
    begin
        vhx      = vx_reg[V_W-1:LO_W];
        vhy      = vy_reg[V_W-1:LO_W];
        plx_next = PL_W'(vx_reg[LO_W-1:0]) * PL_W'(GAIN_Q30);
        ply_next = PL_W'(vy_reg[LO_W-1:0]) * PL_W'(GAIN_Q30);
        phx_next = PH_W'(vhx) * PH_W'(GAIN_S);
        phy_next = PH_W'(vhy) * PH_W'(GAIN_S);
    end

    // combine and drop to guard precision
    always_comb
    begin
        sumx    = (S_W'(phx_reg) <<< LO_W) + S_W'($signed({1'b0, plx_reg}));
        sumy    = (S_W'(phy_reg) <<< LO_W) + S_W'($signed({1'b0, ply_reg}));
        shx     = sumx >>> GAIN_SHIFT;
        shy     = sumy >>> GAIN_SHIFT;
        x3_next = shx[DP_W-1:0];
        y3_next = shy[DP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        z1_reg  <= z1_next;
        plx_reg <= plx_next;
        ply_reg <= ply_next;
        phx_reg <= phx_next;
        phy_reg <= phy_next;
        z2_reg  <= z1_reg;
        x3_reg  <= x3_next;
        y3_reg  <= y3_next;
        z3_reg  <= z2_reg;
    end

    assign tag_o = tag3_reg;
    assign x_o   = x3_reg;
    assign y_o   = y3_reg;
    assign z_o   = z3_reg;

endmodule

// ----- sv/pft_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pft_cordic_cell: one rotation step
// Turns the vector toward the residual angle by the arctangent of 2^-idx
// and hands the result to the next cell.
// ----------------------------------------------------------------------------
module pft_cordic_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [pft_pkg::ATAN_IDX_W-1:0]        idx,
    input  pft_pkg::tag_t                         tag_i,
    input  logic signed [pft_pkg::DP_W-1:0]       x_i,
    input  logic signed [pft_pkg::DP_W-1:0]       y_i,
    input  logic [pft_pkg::ZW-1:0]                z_i,
    output pft_pkg::tag_t                         tag_o,
    output logic signed [pft_pkg::DP_W-1:0]       x_o,
    output logic signed [pft_pkg::DP_W-1:0]       y_o,
    output logic [pft_pkg::ZW-1:0]                z_o
);
    import pft_pkg::*;

    tag_t                   tag_reg;
    logic signed [DP_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [ZW-1:0]          z_reg, z_next;
    logic signed [DP_W-1:0] dx, dy;
    logic [ZW-1:0]          at;

    always_comb
    begin
        dx = y_i >>> idx;
        dy = x_i >>> idx;
        at = atan_value(idx);
        if (!z_i[ZW-1])
        begin
            x_next = x_i - dx;
            y_next = y_i + dy;
            z_next = z_i - at;
        end
        else
        begin
            x_next = x_i + dx;
            y_next = y_i - dy;
            z_next = z_i + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_i;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign tag_o = tag_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

// ----- sv/pft_post.sv -----
// ----------------------------------------------------------------------------
// pft_post: rounding, position add and saturation
// Rounds the rotated vector, adds the position for the local to global
// transaction, clamps to the coordinate range and drives the result.
// ----------------------------------------------------------------------------
module pft_post (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pft_pkg::tag_t                          tag_i,
    input  logic signed [pft_pkg::DP_W-1:0]        x_i,
    input  logic signed [pft_pkg::DP_W-1:0]        y_i,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] pose_x,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] pose_y,
    output logic                                   done,
    output logic signed [pft_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [pft_pkg::COORD_WIDTH-1:0] out_y,
    output logic [pft_pkg::ANGLE_WIDTH-1:0]        out_angle,
    output logic                                   saturated
);
    import pft_pkg::*;

    localparam logic signed [DP_W-1:0] HALF = DP_W'(1) <<< (GUARD_BITS - 1);

    tag_t                  tag_reg;
    logic signed [R_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic                  done_reg;
    logic signed [COORD_WIDTH-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [ANGLE_WIDTH-1:0] oa_reg, oa_next;
    logic                  sat_reg, sat_next;

    logic signed [DP_W-1:0] tx, ty;
    logic signed [R_W:0]    sx, sy;
    logic                   hix, lox, hiy, loy;

    always_comb
    begin
        tx      = (x_i + HALF) >>> GUARD_BITS;
        ty      = (y_i + HALF) >>> GUARD_BITS;
        rx_next = tx[R_W-1:0];
        ry_next = ty[R_W-1:0];
    end

    always_comb
    begin
        if (tag_reg.cmd == CMD_PT_TO_GLOBAL)
        begin
            sx = (R_W+1)'(rx_reg) + (R_W+1)'(pose_x);
            sy = (R_W+1)'(ry_reg) + (R_W+1)'(pose_y);
        end
        else
        begin
            sx = (R_W+1)'(rx_reg);
            sy = (R_W+1)'(ry_reg);
        end
        hix = sx > (R_W+1)'(COORD_MAX);
        lox = sx < (R_W+1)'(COORD_MIN);
        hiy = sy > (R_W+1)'(COORD_MAX);
        loy = sy < (R_W+1)'(COORD_MIN);
        ox_next  = hix ? COORD_MAX : (lox ? COORD_MIN : sx[COORD_WIDTH-1:0]);
        oy_next  = hiy ? COORD_MAX : (loy ? COORD_MIN : sy[COORD_WIDTH-1:0]);
        sat_next = hix | lox | hiy | loy;
        oa_next  = '0;
        case (tag_reg.cmd)
            CMD_PT_TO_GLOBAL, CMD_PT_TO_LOCAL:
            begin
            end
            default:
            begin
                ox_next  = '0;
                oy_next  = '0;
                sat_next = 1'b0;
                oa_next  = tag_reg.ang;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag_reg  <= tag_i;
            done_reg <= tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        ox_reg  <= ox_next;
        oy_reg  <= oy_next;
        oa_reg  <= oa_next;
        sat_reg <= sat_next;
    end

    assign done      = done_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_angle = oa_reg;
    assign saturated = sat_reg;

endmodule

// ----- sv/pose_frame_transform_unit.sv -----
// ----------------------------------------------------------------------------
// pose_frame_transform_unit: robot frame / world frame transform
// Converts points and headings between the robot frame and the world frame
// using the configured pose (position and heading).
//
// Usage:
//   Configure pose_x, pose_y and pose_heading through cfg_wr_en, cfg_index
//   and cfg_data while no transaction is in flight.
//   A transaction is taken at each clock edge with start high; busy stays
//   low, so one transaction per cycle is sustained.
//   Each result shows on out_x, out_y, out_angle and saturated for exactly
//   one cycle with done high, in start order.
//   The pipeline is the rotation chain of CORDIC_STAGES cells, plus setup,
//   two prescale multiply stages, rounding and the output register.
//   The receiver cannot hold off results; done is a one-cycle strobe.
//   Reset clears the pose to zero and drops all transactions in flight.
// ----------------------------------------------------------------------------
module pose_frame_transform_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [1:0]                             cfg_index,
    input  logic [pft_pkg::COORD_WIDTH-1:0]        cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             cmd,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] in_x,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] in_y,
    input  logic signed [pft_pkg::ANGLE_WIDTH-1:0] in_angle,
    output logic                                   done,
    output logic signed [pft_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [pft_pkg::COORD_WIDTH-1:0] out_y,
    output logic signed [pft_pkg::ANGLE_WIDTH-1:0] out_angle,
    output logic                                   saturated
);
    import pft_pkg::*;

    logic signed [COORD_WIDTH-1:0] pose_x_reg, pose_y_reg;
    logic [ANGLE_WIDTH-1:0]        heading_reg;

    tag_t                   tag_c [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] x_c   [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] y_c   [0:CORDIC_STAGES];
    logic [ZW-1:0]          z_c   [0:CORDIC_STAGES];
    logic [ANGLE_WIDTH-1:0] oa;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_POSE_X:       pose_x_reg  <= cfg_data;
                REG_POSE_Y:       pose_y_reg  <= cfg_data;
                REG_POSE_HEADING: heading_reg <= cfg_data[ANGLE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pft_prescale u_prescale (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start & ~busy),
        .cmd          (cmd),
        .in_x         (in_x),
        .in_y         (in_y),
        .in_angle     (in_angle),
        .pose_x       (pose_x_reg),
        .pose_y       (pose_y_reg),
        .pose_heading (heading_reg),
        .tag_o        (tag_c[0]),
        .x_o          (x_c[0]),
        .y_o          (y_c[0]),
        .z_o          (z_c[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        pft_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .idx   (ATAN_IDX_W'(g)),
            .tag_i (tag_c[g]),
            .x_i   (x_c[g]),
            .y_i   (y_c[g]),
            .z_i   (z_c[g]),
            .tag_o (tag_c[g+1]),
            .x_o   (x_c[g+1]),
            .y_o   (y_c[g+1]),
            .z_o   (z_c[g+1])
        );
    end

    pft_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_i     (tag_c[CORDIC_STAGES]),
        .x_i       (x_c[CORDIC_STAGES]),
        .y_i       (y_c[CORDIC_STAGES]),
        .pose_x    (pose_x_reg),
        .pose_y    (pose_y_reg),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_angle (oa),
        .saturated (saturated)
    );

    assign out_angle = $signed(oa);

endmodule

// ----- sv/pft_checker.sv -----
// ----------------------------------------------------------------------------
// pft_checker: port-level checks for pose_frame_transform_unit
// Fixed latency, no spurious results, zeroed fields per command class and
// saturation only at the range limits.
// ----------------------------------------------------------------------------
module pft_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [1:0]                             cmd,
    input  logic                                   done,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] out_x,
    input  logic signed [pft_pkg::COORD_WIDTH-1:0] out_y,
    input  logic signed [pft_pkg::ANGLE_WIDTH-1:0] out_angle,
    input  logic                                   saturated
);
    import pft_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_LATENCY done)
        else $error("transaction result missing at fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(rst_n, PIPE_LATENCY) |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without matching transaction");

    a_angle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(rst_n, PIPE_LATENCY)
        && ($past(cmd, PIPE_LATENCY) == CMD_ANG_TO_GLOBAL
            || $past(cmd, PIPE_LATENCY) == CMD_ANG_TO_LOCAL)
        |-> out_x == '0 && out_y == '0 && !saturated)
        else $error("angle transaction with nonzero coordinates");

    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(rst_n, PIPE_LATENCY)
        && ($past(cmd, PIPE_LATENCY) == CMD_PT_TO_GLOBAL
            || $past(cmd, PIPE_LATENCY) == CMD_PT_TO_LOCAL)
        |-> out_angle == '0)
        else $error("point transaction with nonzero angle");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> out_x == COORD_MAX || out_x == COORD_MIN
        || out_y == COORD_MAX || out_y == COORD_MIN)
        else $error("saturation flagged away from range limits");

endmodule

bind pose_frame_transform_unit pft_checker u_pft_checker (.*);

// ----- verif/pose_frame_transform_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pose_frame_transform_unit_tb: self-checking bench for the pose transform
// A short directed table of extreme points, headings and poses, followed by
// random transactions under a series of random poses. Each accepted
// transaction is mirrored by a local frame transform model. Every result
// strobe is compared field by field against the oldest expected transform.
// Start idles randomly but for the back-to-back phases, and the pose is
// rewritten only while nothing is in flight.
// ----------------------------------------------------------------------------
module pose_frame_transform_unit_tb;

    import pft_pkg::*;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [ANGLE_WIDTH-1:0] ang;
        logic                          sat;
    } xform_result_t;

    typedef struct packed {
        logic                          pose_row;
        cmd_t                          op;
        logic signed [COORD_WIDTH-1:0] a;
        logic signed [COORD_WIDTH-1:0] b;
        logic signed [ANGLE_WIDTH-1:0] c;
        logic                          typed;
        xform_result_t                 want;
    } dir_row_t;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MAX = 16'sh7FFF;
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MIN = 16'sh8000;

    localparam longint C_HI      = 64'sd8388607;
    localparam longint C_LO      = -64'sd8388608;
    localparam longint GAIN      = 64'sd652032874;
    localparam int     PRE_SHIFT = 14;
    localparam longint HALF_LSB  = 64'sd32768;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int N_PHASES        = 13;

    localparam logic [31:0] ATAN_TAB [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    localparam logic [ANGLE_WIDTH-1:0] ANG_EDGES [10] = '{
        16'h0000, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
        16'h8000, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF
    };

    localparam xform_result_t NO_RESULT = '0;

    localparam int N_DIR = 25;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{1'b0, CMD_ANG_TO_GLOBAL, 24'sd0, 24'sd0, ANG_MAX, 1'b1,
          '{24'sd0, 24'sd0, ANG_MAX, 1'b0}},
        '{1'b0, CMD_ANG_TO_LOCAL, COORD_MAX, COORD_MIN, ANG_MIN, 1'b1,
          '{24'sd0, 24'sd0, ANG_MIN, 1'b0}},
        '{1'b0, CMD_PT_TO_GLOBAL, 24'sd0, 24'sd0, ANG_MAX, 1'b1, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, 24'sd0, 24'sd0, ANG_MIN, 1'b1, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, COORD_MAX, COORD_MAX, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, COORD_MIN, COORD_MIN, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, 24'sd256, -24'sd256, 16'sd0, 1'b0, NO_RESULT},
        '{1'b1, CMD_PT_TO_GLOBAL, COORD_MAX, COORD_MAX, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, COORD_MAX, COORD_MAX, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, COORD_MIN, COORD_MIN, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_ANG_TO_GLOBAL, 24'sd0, 24'sd0, ANG_MAX, 1'b1,
          '{24'sd0, 24'sd0, ANG_MAX, 1'b0}},
        '{1'b1, CMD_PT_TO_GLOBAL, COORD_MIN, COORD_MIN, ANG_MIN, 1'b0, NO_RESULT},
        '{1'b0, CMD_ANG_TO_GLOBAL, 24'sd0, 24'sd0, ANG_MIN, 1'b1,
          '{24'sd0, 24'sd0, 16'sd0, 1'b0}},
        '{1'b0, CMD_ANG_TO_LOCAL, 24'sd0, 24'sd0, ANG_MAX, 1'b1,
          '{24'sd0, 24'sd0, -16'sd1, 1'b0}},
        '{1'b0, CMD_PT_TO_GLOBAL, COORD_MIN, COORD_MIN, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, COORD_MAX, COORD_MAX, 16'sd0, 1'b0, NO_RESULT},
        '{1'b1, CMD_PT_TO_GLOBAL, 24'sd0, 24'sd0, 16'sh4000, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, 24'sd256, 24'sd0, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, 24'sd0, 24'sd256, 16'sd0, 1'b0, NO_RESULT},
        '{1'b1, CMD_PT_TO_GLOBAL, 24'sd0, 24'sd0, 16'shBFFF, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, 24'sd1000, -24'sd1000, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_LOCAL, -24'sd1, 24'sd1, 16'sd0, 1'b0, NO_RESULT},
        '{1'b1, CMD_PT_TO_GLOBAL, 24'sd1280, -24'sd1280, 16'sh2000, 1'b0, NO_RESULT},
        '{1'b0, CMD_PT_TO_GLOBAL, 24'sd512, 24'sd512, 16'sd0, 1'b0, NO_RESULT},
        '{1'b0, CMD_ANG_TO_LOCAL, 24'sd0, 24'sd0, 16'sd0, 1'b0, NO_RESULT}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [1:0]                    cfg_index;
    logic [COORD_WIDTH-1:0]        cfg_data;
    logic                          start;
    logic                          busy;
    logic [1:0]                    cmd;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [ANGLE_WIDTH-1:0] in_angle;
    logic                          done;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [ANGLE_WIDTH-1:0] out_angle;
    logic                          saturated;

    logic signed [COORD_WIDTH-1:0] pose_x_m;
    logic signed [COORD_WIDTH-1:0] pose_y_m;
    logic signed [ANGLE_WIDTH-1:0] pose_h_m;

    xform_result_t awaited_transforms[$];

    int max_gap;
    int n_errors;
    int n_results;
    int n_clipped;
    int n_poses;
    int n_by_cmd [4];

    pose_frame_transform_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_angle  (in_angle),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_angle (out_angle),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("pose_frame_transform_unit_tb NOT OK");
        $finish;
    end

    function automatic void rotate_vec(input longint vx_in, input longint vy_in,
                                       input logic [31:0] z_in,
                                       output longint rx, output longint ry);
        longint      vx;
        longint      vy;
        longint      dx;
        longint      dy;
        logic [31:0] z;
        int          i;
        vx = vx_in;
        vy = vy_in;
        z  = z_in;
        // fold the second and third quadrants onto the first and fourth
        if (z[31] != z[30])
        begin
            vx = -vx;
            vy = -vy;
            z  = z + 32'h8000_0000;
        end
        vx = (vx * GAIN) >>> PRE_SHIFT;
        vy = (vy * GAIN) >>> PRE_SHIFT;
        for (i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (!z[31])
            begin
                vx -= dx;
                vy += dy;
                z  -= ATAN_TAB[i];
            end
            else
            begin
                vx += dx;
                vy -= dy;
                z  += ATAN_TAB[i];
            end
        end
        rx = (vx + HALF_LSB) >>> GUARD_BITS;
        ry = (vy + HALF_LSB) >>> GUARD_BITS;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > C_HI)
            return C_HI;
        if (v < C_LO)
            return C_LO;
        return v;
    endfunction

    function automatic xform_result_t transform_item(input cmd_t op,
                                                     input logic signed [COORD_WIDTH-1:0] x,
                                                     input logic signed [COORD_WIDTH-1:0] y,
                                                     input logic signed [ANGLE_WIDTH-1:0] a);
        xform_result_t r;
        longint        rx;
        longint        ry;
        longint        cx;
        longint        cy;
        logic [31:0]   h;
        r = '0;
        h = {pose_h_m, 16'h0000};
        if (op == CMD_ANG_TO_GLOBAL)
            r.ang = a + pose_h_m;
        else if (op == CMD_ANG_TO_LOCAL)
            r.ang = a - pose_h_m;
        else
        begin
            if (op == CMD_PT_TO_GLOBAL)
            begin
                rotate_vec(longint'(x), longint'(y), h, rx, ry);
                rx += longint'(pose_x_m);
                ry += longint'(pose_y_m);
            end
            else
                rotate_vec(longint'(x) - longint'(pose_x_m),
                           longint'(y) - longint'(pose_y_m), 32'd0 - h, rx, ry);
            cx    = clamp_coord(rx);
            cy    = clamp_coord(ry);
            r.x   = cx[COORD_WIDTH-1:0];
            r.y   = cy[COORD_WIDTH-1:0];
            r.sat = (cx != rx) || (cy != ry);
        end
        return r;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        int k;
        int s;
        k = $urandom_range(0, 9);
        s = int'($urandom_range(0, 8192)) - 4096;
        if (k <= 4)
            return COORD_WIDTH'($urandom);
        if (k <= 6)
            return COORD_WIDTH'(s);
        if (k == 7)
            return COORD_MAX;
        if (k == 8)
            return COORD_MIN;
        return COORD_WIDTH'(s / 1024);
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
        if ($urandom_range(0, 1) == 0)
            return ANGLE_WIDTH'($urandom);
        return ANG_EDGES[$urandom_range(0, 9)];
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic set_pose(input logic signed [COORD_WIDTH-1:0] px,
                            input logic signed [COORD_WIDTH-1:0] py,
                            input logic signed [ANGLE_WIDTH-1:0] ph);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_POSE_X;
        cfg_data  <= px;
        @(posedge clk);
        cfg_index <= REG_POSE_Y;
        cfg_data  <= py;
        @(posedge clk);
        cfg_index <= REG_POSE_HEADING;
        cfg_data  <= {8'($urandom), ph};
        @(posedge clk);
        // unmapped index: must leave the pose alone
        cfg_index <= REG_UNUSED;
        cfg_data  <= COORD_WIDTH'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pose_x_m = px;
        pose_y_m = py;
        pose_h_m = ph;
        n_poses++;
    endtask

    task automatic send_item(input cmd_t op,
                             input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [ANGLE_WIDTH-1:0] a,
                             input logic typed, input xform_result_t want);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= op;
        in_x     <= x;
        in_y     <= y;
        in_angle <= a;
        do
            @(posedge clk);
        while (busy);
        awaited_transforms.push_back(typed ? want : transform_item(op, x, y, a));
        n_by_cmd[op]++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (awaited_transforms.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : watch_results
        xform_result_t w;
        if (rst_n && done)
        begin
            if (awaited_transforms.size() == 0)
                report_mismatch($sformatf("result with nothing pending x=%0d y=%0d ang=%0d",
                                          out_x, out_y, out_angle));
            else
            begin
                w = awaited_transforms.pop_front();
                if (out_x !== w.x)
                    report_mismatch($sformatf("out_x %0d, want %0d", out_x, w.x));
                if (out_y !== w.y)
                    report_mismatch($sformatf("out_y %0d, want %0d", out_y, w.y));
                if (out_angle !== w.ang)
                    report_mismatch($sformatf("out_angle %0d, want %0d", out_angle, w.ang));
                if (saturated !== w.sat)
                    report_mismatch($sformatf("saturated %b, want %b", saturated, w.sat));
                n_results++;
                if (saturated === 1'b1)
                    n_clipped++;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_POSE_X;
        cfg_data  <= '0;
        start     <= 1'b0;
        cmd       <= CMD_PT_TO_GLOBAL;
        in_x      <= '0;
        in_y      <= '0;
        in_angle  <= '0;
        pose_x_m  = '0;
        pose_y_m  = '0;
        pose_h_m  = '0;
        max_gap   = 8;
        n_errors  = 0;
        n_results = 0;
        n_clipped = 0;
        n_poses   = 0;
        n_by_cmd  = '{0, 0, 0, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIR_ROWS[i].pose_row)
            begin
                drain();
                set_pose(DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].c);
            end
            else
                send_item(DIR_ROWS[i].op, DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].c,
                          DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            set_pose(pick_coord(), pick_coord(), pick_angle());
            // every third phase runs back to back
            max_gap = (p % 3 == 0) ? 0 : 8;
            repeat (ITEMS_PER_PHASE)
                send_item(cmd_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                          pick_angle(), 1'b0, NO_RESULT);
        end

        drain();
        repeat (PIPE_LATENCY + 10) @(posedge clk);

        $display("covered %0d transactions: %0d/%0d points to world/robot, %0d/%0d headings",
                 n_results, n_by_cmd[CMD_PT_TO_GLOBAL], n_by_cmd[CMD_PT_TO_LOCAL],
                 n_by_cmd[CMD_ANG_TO_GLOBAL], n_by_cmd[CMD_ANG_TO_LOCAL]);
        $display("across %0d pose settings, %0d results clipped, %0d mismatches",
                 n_poses, n_clipped, n_errors);
        if (n_errors == 0)
            $display("pose_frame_transform_unit_tb OK");
        else
            $display("pose_frame_transform_unit_tb NOT OK");
        $finish;
    end

endmodule
